[sv/napt_header_rewrite_defines.svh]
// Assertion macros shared by the translator RTL.
`ifndef NAPT_HEADER_REWRITE_DEFINES_SVH
`define NAPT_HEADER_REWRITE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NAPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NAPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/napt_pkg.sv]
`default_nettype none

package napt_pkg;

	localparam logic [15:0] FRAME_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP       = 8'h06;
	localparam logic [7:0]  PROTO_UDP       = 8'h11;

	localparam logic [31:0] RST_NAT_ADDR     = 32'hC0A8_0A04;
	localparam logic [31:0] RST_INSIDE_ADDR  = 32'hC0A8_0A02;
	localparam logic [31:0] RST_OUTSIDE_ADDR = 32'hC0A8_0A03;
	localparam logic [15:0] RST_INSIDE_PORT  = 16'd26001;
	localparam logic [15:0] RST_OUTSIDE_PORT = 16'd22;
	localparam logic [15:0] RST_PUB_PORT     = 16'd44001;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int S_TDATA_W   = 152;
	localparam int S_TUSER_W   = 1;
	localparam int M_TDATA_W   = 128;
	localparam int M_TUSER_W   = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NAT_ADDR     = 3'd0,
		CFG_INSIDE_ADDR  = 3'd1,
		CFG_OUTSIDE_ADDR = 3'd2,
		CFG_INSIDE_PORT  = 3'd3,
		CFG_OUTSIDE_PORT = 3'd4,
		CFG_PUB_PORT     = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STATUS_NOT_IPV4   = 2'd0,
		STATUS_BAD_PROTO  = 2'd1,
		STATUS_NO_MATCH   = 2'd2,
		STATUS_REWRITTEN  = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] nat_addr;
		logic [31:0] inside_addr;
		logic [31:0] outside_addr;
		logic [15:0] inside_port;
		logic [15:0] outside_port;
		logic [15:0] pub_port;
	} napt_cfg_t;

	typedef struct packed {
		logic        direction;
		logic [15:0] frame_type;
		logic [7:0]  protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] ip_checksum;
		logic [15:0] l4_checksum;
	} hdr_in_t;

	typedef struct packed {
		logic        out_gate;
		status_t     status;
		logic [31:0] new_source_address;
		logic [31:0] new_dest_address;
		logic [15:0] new_source_port;
		logic [15:0] new_dest_port;
		logic [15:0] new_ip_checksum;
		logic [15:0] new_l4_checksum;
	} hdr_out_t;

	// Fold a sum of 16-bit words to a ones-complement word (end-around carry twice).
	function automatic logic [15:0] oc_fold(input logic [19:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

`default_nettype wire

[sv/napt_xlate.sv]
`default_nettype none

module napt_xlate
	import napt_pkg::*;
(
	input  napt_cfg_t cfg,
	input  hdr_in_t   hdr,
	output hdr_out_t  res
);

	logic        is_ipv4;
	logic        is_l4;
	logic        out_hit;
	logic        in_hit;
	logic        rewrite;
	logic        keep_l4;
	logic [31:0] nsa;
	logic [31:0] nda;
	logic [15:0] nsp;
	logic [15:0] ndp;
	logic [15:0] sa_hi_n;
	logic [15:0] sa_lo_n;
	logic [15:0] da_hi_n;
	logic [15:0] da_lo_n;
	logic [15:0] sp_n;
	logic [15:0] dp_n;
	logic [15:0] ipc_n;
	logic [15:0] l4c_n;
	logic [18:0] addr_sum;
	logic [19:0] ip_sum;
	logic [19:0] l4_sum;
	logic [15:0] ip_new;
	logic [15:0] l4_raw;
	logic [15:0] l4_new;

	assign is_ipv4 = hdr.frame_type == FRAME_TYPE_IPV4;
	assign is_l4   = hdr.protocol == PROTO_TCP || hdr.protocol == PROTO_UDP;

	assign out_hit = is_ipv4 && is_l4 && !hdr.direction &&
		hdr.source_address == cfg.inside_addr && hdr.source_port == cfg.inside_port &&
		hdr.dest_address == cfg.outside_addr && hdr.dest_port == cfg.outside_port;
	assign in_hit = is_ipv4 && is_l4 && hdr.direction &&
		hdr.dest_address == cfg.nat_addr && hdr.dest_port == cfg.pub_port &&
		hdr.source_address == cfg.outside_addr && hdr.source_port == cfg.outside_port;
	assign rewrite = out_hit || in_hit;

	assign nsa = out_hit ? cfg.nat_addr : hdr.source_address;
	assign nsp = out_hit ? cfg.pub_port : hdr.source_port;
	assign nda = in_hit ? cfg.inside_addr : hdr.dest_address;
	assign ndp = in_hit ? cfg.inside_port : hdr.dest_port;

	assign sa_hi_n = ~hdr.source_address[31:16];
	assign sa_lo_n = ~hdr.source_address[15:0];
	assign da_hi_n = ~hdr.dest_address[31:16];
	assign da_lo_n = ~hdr.dest_address[15:0];
	assign sp_n    = ~hdr.source_port;
	assign dp_n    = ~hdr.dest_port;
	assign ipc_n   = ~hdr.ip_checksum;
	assign l4c_n   = ~hdr.l4_checksum;

	// Incremental update: ~HC + sum of (~old + new) over every changed word.
	assign addr_sum = {3'd0, sa_hi_n} + {3'd0, nsa[31:16]} + {3'd0, sa_lo_n} +
		{3'd0, nsa[15:0]} + {3'd0, da_hi_n} + {3'd0, nda[31:16]} +
		{3'd0, da_lo_n} + {3'd0, nda[15:0]};
	assign ip_sum = {1'b0, addr_sum} + {4'd0, ipc_n};
	assign l4_sum = {1'b0, addr_sum} + {4'd0, l4c_n} + {4'd0, sp_n} + {4'd0, nsp} +
		{4'd0, dp_n} + {4'd0, ndp};

	assign ip_new  = ~oc_fold(ip_sum);
	assign l4_raw  = ~oc_fold(l4_sum);
	assign l4_new  = (l4_raw == 16'd0) ? 16'hFFFF : l4_raw;
	// UDP with a zero checksum carries none; leave it zero.
	assign keep_l4 = hdr.protocol == PROTO_UDP && hdr.l4_checksum == 16'd0;

	always_comb begin
		res.out_gate           = hdr.direction;
		res.new_source_address = nsa;
		res.new_dest_address   = nda;
		res.new_source_port    = nsp;
		res.new_dest_port      = ndp;
		res.new_ip_checksum    = rewrite ? ip_new : hdr.ip_checksum;
		res.new_l4_checksum    = (rewrite && !keep_l4) ? l4_new : hdr.l4_checksum;
		if (!is_ipv4) begin
			res.status = STATUS_NOT_IPV4;
		end else if (!is_l4) begin
			res.status = STATUS_BAD_PROTO;
		end else if (!rewrite) begin
			res.status = STATUS_NO_MATCH;
		end else begin
			res.status = STATUS_REWRITTEN;
		end
	end

endmodule

`default_nettype wire

[sv/napt_header_rewrite.sv]
// Static address and port translator for one mapped TCP/UDP flow.
// s_axis carries one parsed packet header per transaction, with the arrival
// side in tuser; m_axis returns the translated header, the status code and
// the updated IPv4 and TCP/UDP checksums, with the output side in tuser.
// Outbound hits get the NAT source ip:port, inbound hits get the inside
// destination ip:port; everything else passes through with its status.
// The cfg channel writes the six flow registers by index; it is always
// ready and should only be used while no transaction is in flight.
// An input transaction passes through one input register, then the match
// and checksum logic into the output register; m_axis_tvalid follows the
// input stage valid flag through that output register.
// Throughput is one header per cycle while m_axis is not stalled, set by the two-stage register pipe.
// When m_axis stalls, the output register holds its transaction and the
// input register still takes one more; s_axis_tready drops only when both
// stages are full and m_axis_tready is low.
// Reset clears both stage valid flags and loads the default flow mapping.
`default_nettype none
`include "napt_header_rewrite_defines.svh"

module napt_header_rewrite
	import napt_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,

	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_INDEX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data,

	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	// frame_type, protocol, source_address, dest_address, source_port,
	// dest_port, ip_checksum, l4_checksum
	input  wire  [S_TDATA_W-1:0]   s_axis_tdata,
	// direction
	input  wire  [S_TUSER_W-1:0]   s_axis_tuser,

	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	// new_source_address, new_dest_address, new_source_port, new_dest_port,
	// new_ip_checksum, new_l4_checksum
	output logic [M_TDATA_W-1:0]   m_axis_tdata,
	// out_gate, status
	output logic [M_TUSER_W-1:0]   m_axis_tuser
);

	napt_cfg_t cfg_q;
	hdr_in_t   hdr_in;
	hdr_in_t   hdr_s1;
	hdr_out_t  res_s1;
	hdr_out_t  res_s2;
	logic      valid_s1;
	logic      valid_s2;
	logic      en_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nat_addr     <= RST_NAT_ADDR;
			cfg_q.inside_addr  <= RST_INSIDE_ADDR;
			cfg_q.outside_addr <= RST_OUTSIDE_ADDR;
			cfg_q.inside_port  <= RST_INSIDE_PORT;
			cfg_q.outside_port <= RST_OUTSIDE_PORT;
			cfg_q.pub_port     <= RST_PUB_PORT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NAT_ADDR:     cfg_q.nat_addr     <= cfg_data;
				CFG_INSIDE_ADDR:  cfg_q.inside_addr  <= cfg_data;
				CFG_OUTSIDE_ADDR: cfg_q.outside_addr <= cfg_data;
				CFG_INSIDE_PORT:  cfg_q.inside_port  <= cfg_data[15:0];
				CFG_OUTSIDE_PORT: cfg_q.outside_port <= cfg_data[15:0];
				CFG_PUB_PORT:     cfg_q.pub_port     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign hdr_in.direction      = s_axis_tuser[0];
	assign hdr_in.frame_type     = s_axis_tdata[15:0];
	assign hdr_in.protocol       = s_axis_tdata[23:16];
	assign hdr_in.source_address = s_axis_tdata[55:24];
	assign hdr_in.dest_address   = s_axis_tdata[87:56];
	assign hdr_in.source_port    = s_axis_tdata[103:88];
	assign hdr_in.dest_port      = s_axis_tdata[119:104];
	assign hdr_in.ip_checksum    = s_axis_tdata[135:120];
	assign hdr_in.l4_checksum    = s_axis_tdata[151:136];

	assign en_s2         = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			hdr_s1 <= hdr_in;
		end
		if (en_s2 && valid_s1) begin
			res_s2 <= res_s1;
		end
	end

	napt_xlate u_xlate (
		.cfg (cfg_q),
		.hdr (hdr_s1),
		.res (res_s1)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.new_l4_checksum, res_s2.new_ip_checksum,
		res_s2.new_dest_port, res_s2.new_source_port,
		res_s2.new_dest_address, res_s2.new_source_address};
	assign m_axis_tuser  = {res_s2.status, res_s2.out_gate};

	`NAPT_ASSERT_NXT(a_s1_to_s2, valid_s1 && en_s2, valid_s2, "stage one transaction lost")
	`NAPT_ASSERT_IMP(a_stall_only_full, !s_axis_tready, valid_s1 && valid_s2 && !m_axis_tready, "input stalled with room")
	`NAPT_ASSERT_NXT(a_s1_hold, valid_s1 && !en_s2, valid_s1 && $stable(hdr_s1), "stalled stage one changed")

endmodule

`default_nettype wire
